>>> src/luminance_histogram_unit_defines.svh
// ----------------------------------------------------------------------------
// luminance histogram unit assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef LUMINANCE_HISTOGRAM_UNIT_DEFINES_SVH
`define LUMINANCE_HISTOGRAM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LHU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("luminance histogram assertion failed");
`define LHU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("luminance histogram assertion failed");
`else
`define LHU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LHU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/lhist_pkg.sv
// ----------------------------------------------------------------------------
// lhist_pkg
// types, codes and defaults of the luminance histogram unit
// ----------------------------------------------------------------------------
package lhist_pkg;

  localparam int BINS_DEF      = 131072;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W = 17;
  localparam int WEIGHT_W = 17;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_RED   = 2'd0,
    REG_WEIGHT_GREEN = 2'd1,
    REG_WEIGHT_BLUE  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 17'd13933;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 17'd46871;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 17'd4732;

  typedef struct packed {
    logic [1:0]          action;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  bin_count;
    logic [SAMPLE_W-1:0] bin_echo;
  } out_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] red;
    logic [WEIGHT_W-1:0] green;
    logic [WEIGHT_W-1:0] blue;
  } weights_t;

endpackage

>>> src/lhist_ram.sv
// ----------------------------------------------------------------------------
// lhist_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module lhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/lhist_luma.sv
// ----------------------------------------------------------------------------
// lhist_luma
// weighted luma sum in two register stages, then shift and clamp to a bin
// ----------------------------------------------------------------------------
module lhist_luma #(
  parameter int BINS      = lhist_pkg::BINS_DEF,
  parameter int FRAC_BITS = lhist_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  lhist_pkg::weights_t     weights,
  input  lhist_pkg::in_t          item,
  output logic [$clog2(BINS)-1:0] bin
);
  import lhist_pkg::*;

  localparam int ADDR_W = $clog2(BINS);
  localparam logic [SUM_W-1:0] BIN_MAX = SUM_W'(BINS - 1);

  logic [PROD_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  shifted;

  // stage one: products
  always_ff @(posedge clk) begin
    prod_r_r <= PROD_W'(weights.red)   * PROD_W'(item.red);
    prod_g_r <= PROD_W'(weights.green) * PROD_W'(item.green);
    prod_b_r <= PROD_W'(weights.blue)  * PROD_W'(item.blue);
  end

  // stage two: sum
  always_ff @(posedge clk) begin
    sum_r <= SUM_W'(prod_r_r) + SUM_W'(prod_g_r) + SUM_W'(prod_b_r);
  end

  assign shifted = sum_r >> FRAC_BITS;
  assign bin     = (shifted > BIN_MAX) ? BIN_MAX[ADDR_W-1:0] : shifted[ADDR_W-1:0];

endmodule

>>> src/luminance_histogram_unit.sv
// ----------------------------------------------------------------------------
// luminance_histogram_unit
// pixel: busy through multiply, sum, bin read and write back
// read: busy through the bin read and response states, then the result strobe; one item at a time
// clear: busy while every bin is zeroed, one bin written per cycle through the ram write port
// reset loads the default weights and runs the same clear sweep, busy high
// ----------------------------------------------------------------------------
`include "luminance_histogram_unit_defines.svh"

module luminance_histogram_unit #(
  parameter int BINS      = lhist_pkg::BINS_DEF,
  parameter int FRAC_BITS = lhist_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  lhist_pkg::in_t                       in_data,
  output logic                                 out_valid,
  output lhist_pkg::out_t                      out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lhist_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lhist_pkg::WEIGHT_W-1:0]       cfg_data
);
  import lhist_pkg::*;

  localparam int ADDR_W = $clog2(BINS);
  localparam logic [ADDR_W-1:0]   LAST_BIN  = ADDR_W'(BINS - 1);
  localparam logic [SAMPLE_W:0]   BINS_WIDE = (SAMPLE_W + 1)'(BINS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_MUL,
    S_ADD,
    S_RD,
    S_WR,
    S_RSP
  } state_t;

  state_t              state_r;
  in_t                 item_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic                in_range_r;
  logic                out_valid_r;
  out_t                out_r;
  weights_t            weights_r;

  logic                accept;
  logic [ADDR_W-1:0]   luma_bin;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [COUNT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [COUNT_W-1:0]  ram_rdata;
  logic [COUNT_W-1:0]  count_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.red   <= WEIGHT_RED_RST;
      weights_r.green <= WEIGHT_GREEN_RST;
      weights_r.blue  <= WEIGHT_BLUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_RED:   weights_r.red   <= cfg_data;
        REG_WEIGHT_GREEN: weights_r.green <= cfg_data;
        REG_WEIGHT_BLUE:  weights_r.blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  lhist_luma #(
    .BINS      (BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_luma (
    .clk     (clk),
    .weights (weights_r),
    .item    (item_r),
    .bin     (luma_bin)
  );

  // read port: luma bin for pixels, requested bin for reads
  assign ram_raddr = (action_t'(item_r.action) == ACT_PIXEL) ?
                     luma_bin : item_r.bin_index[ADDR_W-1:0];

  // saturating increment
  assign count_inc = (ram_rdata == {COUNT_W{1'b1}}) ? ram_rdata : ram_rdata + COUNT_W'(1);

  assign ram_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : count_inc;

  lhist_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            unique case (action_t'(in_data.action))
              ACT_CLEAR: begin
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end
              ACT_PIXEL: state_r <= S_MUL;
              ACT_READ:  state_r <= S_RD;
              ACT_NONE:  state_r <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == LAST_BIN) begin
            state_r <= S_IDLE;
          end
        end
        S_MUL: state_r <= S_ADD;
        S_ADD: state_r <= S_RD;
        S_RD: begin
          addr_r     <= ram_raddr;
          in_range_r <= ({1'b0, item_r.bin_index} < BINS_WIDE);
          if (action_t'(item_r.action) == ACT_PIXEL) begin
            state_r <= S_WR;
          end else begin
            state_r <= S_RSP;
          end
        end
        S_WR: state_r <= S_IDLE;
        S_RSP: begin
          out_valid_r        <= 1'b1;
          out_r.bin_count    <= in_range_r ? ram_rdata : '0;
          out_r.bin_echo     <= item_r.bin_index;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LHU_ASSERT_NXT(a_rsp_strobe, clk, rst_n, rst_n && state_r == S_RSP, out_valid_r)
  `LHU_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `LHU_ASSERT_IMP(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !ram_we)
  `LHU_ASSERT_NXT(a_read_path, clk, rst_n,
                  accept && in_data.action == ACT_READ, state_r == S_RD)

endmodule

>>> bench/luminance_histogram_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luminance_histogram_unit_tb
// drives clear, pixel and read transactions and weight writes into the
// histogram unit; a software histogram predicts every bin read, and each
// strobed result is compared field by field with the oldest pending read
// ----------------------------------------------------------------------------
module luminance_histogram_unit_tb;
  import lhist_pkg::*;

  localparam int NBINS       = BINS_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int MAX_SAMPLE  = (1 << SAMPLE_W) - 1;
  localparam int MAX_WEIGHT  = (1 << WEIGHT_W) - 1;
  localparam int STALL_LIMIT = 4 * NBINS + 20000;
  localparam int PHASE_ITEMS = 490;
  localparam int POOL_SIZE   = 12;
  localparam int MAX_PRINTS  = 200;

  class luma_hist_board;
    bit [COUNT_W-1:0] tally [NBINS];
    weights_t weights;
    out_t pending_reads [$];
    int mismatches;

    function new();
      clear_tally();
      weights.red   = WEIGHT_RED_RST;
      weights.green = WEIGHT_GREEN_RST;
      weights.blue  = WEIGHT_BLUE_RST;
      mismatches = 0;
    endfunction

    function void clear_tally();
      foreach (tally[i]) tally[i] = '0;
    endfunction

    function int unsigned luma_bin(in_t px);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] y;
      sum = SUM_W'(weights.red) * SUM_W'(px.red)
          + SUM_W'(weights.green) * SUM_W'(px.green)
          + SUM_W'(weights.blue) * SUM_W'(px.blue);
      y = sum >> FRAC;
      if (y > SUM_W'(NBINS - 1)) y = SUM_W'(NBINS - 1);
      return int'(y);
    endfunction

    function void write_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
      case (cfg_reg_t'(idx))
        REG_WEIGHT_RED:   weights.red = val;
        REG_WEIGHT_GREEN: weights.green = val;
        REG_WEIGHT_BLUE:  weights.blue = val;
        default: ;
      endcase
    endfunction

    task flag(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_item(in_t item);
      int unsigned k;
      out_t want;
      case (action_t'(item.action))
        ACT_CLEAR: clear_tally();
        ACT_PIXEL: begin
          k = luma_bin(item);
          if (k < NBINS && tally[k] != '1) tally[k] = tally[k] + 1'b1;
        end
        ACT_READ: begin
          want.bin_echo  = item.bin_index;
          want.bin_count = (int'(item.bin_index) < NBINS) ? tally[item.bin_index] : '0;
          pending_reads.push_back(want);
        end
        default: ;
      endcase
    endfunction

    task check_result(out_t got);
      out_t want;
      if (pending_reads.size() == 0) begin
        flag($sformatf("result for bin %0d with no read pending", got.bin_echo));
      end else begin
        want = pending_reads.pop_front();
        if (got.bin_count !== want.bin_count)
          flag($sformatf("bin_count of bin %0d: got %0d, want %0d",
                         want.bin_echo, got.bin_count, want.bin_count));
        if (got.bin_echo !== want.bin_echo)
          flag($sformatf("bin_echo: got %0d, want %0d", got.bin_echo, want.bin_echo));
      end
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_t                  in_data   = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]  cfg_data  = '0;

  luma_hist_board board;
  int idle_pct = 0;
  int stall_cycles = 0;
  int unsigned hit_bins [$];
  in_t pixel_pool [$];

  luminance_histogram_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_data);
      if (start && !busy) board.note_item(in_data);
      if (cfg_valid && cfg_ready) board.write_weight(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL luminance_histogram_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return SAMPLE_W'(MAX_SAMPLE);
      2: return SAMPLE_W'($urandom_range(255));
      default: return SAMPLE_W'($urandom_range(MAX_SAMPLE));
    endcase
  endfunction

  function automatic in_t make_item(action_t act);
    in_t item;
    item.action    = act;
    item.red       = SAMPLE_W'($urandom);
    item.green     = SAMPLE_W'($urandom);
    item.blue      = SAMPLE_W'($urandom);
    item.bin_index = SAMPLE_W'($urandom);
    return item;
  endfunction

  function automatic in_t pixel_of(int unsigned r, int unsigned g, int unsigned b);
    in_t item;
    item = make_item(ACT_PIXEL);
    item.red   = SAMPLE_W'(r);
    item.green = SAMPLE_W'(g);
    item.blue  = SAMPLE_W'(b);
    return item;
  endfunction

  function automatic in_t read_of(int unsigned idx);
    in_t item;
    item = make_item(ACT_READ);
    item.bin_index = SAMPLE_W'(idx);
    return item;
  endfunction

  function automatic in_t random_item();
    in_t item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      item = pixel_pool[$urandom_range(pixel_pool.size() - 1)];
    end else if (pick < 58) begin
      item = pixel_of(pick_sample(), pick_sample(), pick_sample());
    end else if (pick < 94) begin
      if (hit_bins.size() != 0 && $urandom_range(3) != 0)
        item = read_of(hit_bins[$urandom_range(hit_bins.size() - 1)]);
      else
        item = read_of(pick_sample());
    end else begin
      item = make_item(ACT_NONE);
    end
    if (item.action == ACT_PIXEL) begin
      hit_bins.push_back(board.luma_bin(item));
      if (hit_bins.size() > 64) void'(hit_bins.pop_front());
    end
    return item;
  endfunction

  task automatic send_item(in_t item);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain(int settle);
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_reads.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [WEIGHT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_weights(int unsigned r, int unsigned g, int unsigned b);
    write_reg(REG_WEIGHT_RED, WEIGHT_W'(r));
    write_reg(REG_WEIGHT_GREEN, WEIGHT_W'(g));
    write_reg(REG_WEIGHT_BLUE, WEIGHT_W'(b));
  endtask

  initial begin
    in_t probe [4];
    int clear_at;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes at reset weights, unused action, clear
    probe[0] = pixel_of(MAX_SAMPLE, 0, 0);
    probe[1] = pixel_of(0, MAX_SAMPLE, 0);
    probe[2] = pixel_of(0, 0, MAX_SAMPLE);
    probe[3] = pixel_of(65536, 65536, 65536);
    send_item(read_of(0));
    send_item(read_of(MAX_SAMPLE));
    send_item(pixel_of(0, 0, 0));
    send_item(pixel_of(0, 0, 0));
    send_item(pixel_of(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE));
    foreach (probe[i]) send_item(probe[i]);
    send_item(read_of(0));
    send_item(read_of(MAX_SAMPLE));
    foreach (probe[i]) send_item(read_of(board.luma_bin(probe[i])));
    send_item(make_item(ACT_NONE));
    send_item('1);
    send_item(read_of(0));
    send_item(make_item(ACT_CLEAR));
    send_item(read_of(0));
    send_item(read_of(MAX_SAMPLE));
    send_item(pixel_of(0, 0, 0));
    send_item(read_of(0));

    for (int phase = 0; phase < 4; phase++) begin
      drain(8);
      case (phase)
        0: set_weights(MAX_WEIGHT, MAX_WEIGHT, MAX_WEIGHT);
        1: begin
          set_weights(0, 65536, 0);
          write_reg(REG_UNUSED, WEIGHT_W'($urandom));
        end
        2: set_weights($urandom_range(65536), $urandom_range(65536), $urandom_range(65536));
        default: set_weights(WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST);
      endcase
      case (phase)
        1: idle_pct = 85;
        3: idle_pct = 7;
        default: idle_pct = 0;
      endcase
      hit_bins.delete();
      pixel_pool.delete();
      repeat (POOL_SIZE) pixel_pool.push_back(pixel_of(pick_sample(), pick_sample(),
                                                       pick_sample()));
      clear_at = (phase % 2 == 1) ? $urandom_range(100, 400) : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == clear_at) send_item(make_item(ACT_CLEAR));
        else send_item(random_item());
      end
    end

    drain(16);
    if (board.pending_reads.size() != 0)
      board.flag($sformatf("%0d reads never answered", board.pending_reads.size()));
    if (board.mismatches == 0) begin
      $display("PASS luminance_histogram_unit");
    end else begin
      $display("FAIL luminance_histogram_unit");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/lhist_pkg.sv
src/lhist_ram.sv
src/lhist_luma.sv
src/luminance_histogram_unit.sv
bench/luminance_histogram_unit_tb.sv
